// ----- src/mpba_pkg.sv -----
package mpba_pkg;

  // number of pool table entries
  localparam int unsigned MaxPools = 8;
  localparam int unsigned PoolIdxW = (MaxPools > 1) ? $clog2(MaxPools) : 1;
  localparam int unsigned CountW   = $clog2(MaxPools + 1);

  localparam logic [31:0] ChunkReset = 32'd33554432;

  typedef enum logic [1:0] {
    StatusOk   = 2'd0,
    StatusSkip = 2'd1,
    StatusFull = 2'd2
  } status_e;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpClear = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] size_bytes;
    logic [16:0] alignment;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  pool_index;
    logic [31:0] offset;
    logic        new_pool;
    logic [32:0] new_pool_size;
  } rsp_t;

  // one pool table entry as stored in memory
  typedef struct packed {
    logic [32:0] capacity;
    logic [32:0] fill;
  } pool_t;

endpackage

// ----- src/mpba_ram.sv -----
module mpba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mpba_ctrl.sv -----
module mpba_ctrl
  import mpba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  req_t                req_i,
  input  logic [31:0]         chunk_size_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output rsp_t                rsp_o,
  output logic                ram_we_o,
  output logic [PoolIdxW-1:0] ram_waddr_o,
  output pool_t               ram_wdata_o,
  output logic [PoolIdxW-1:0] ram_raddr_o,
  input  pool_t               ram_rdata_i
);

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SRead  = 6'b000010,
    SAlign = 6'b000100,
    SCheck = 6'b001000,
    SOpen  = 6'b010000,
    SDone  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [PoolIdxW-1:0] idx_q, idx_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [MaxPools-1:0] cleared_q, cleared_d;
  logic [31:0]         size_q, size_d;
  logic [16:0]         align_q, align_d;
  logic [33:0]         at_q, at_d;
  logic [32:0]         cap_q, cap_d;
  rsp_t                rsp_q, rsp_d;

  logic [32:0] fill_rd;
  logic [33:0] amask;
  logic [34:0] end_sum;
  logic        fits;
  logic        last_pool;
  logic [32:0] cmask;
  logic [32:0] rounded;
  logic [32:0] new_cap;

  // fill of the entry just read, zero if a clear came after its last write
  assign fill_rd = cleared_q[idx_q] ? 33'd0 : ram_rdata_i.fill;
  assign amask   = 34'(align_q) - 34'd1;
  assign end_sum = {1'b0, at_q} + 35'(size_q);
  assign fits    = end_sum <= {2'b00, cap_q};
  assign last_pool = (CountW'(idx_q) + CountW'(1)) == count_q;

  // new pool capacity: chunk, or request rounded up to a chunk multiple
  assign cmask = 33'(chunk_size_i) - 33'd1;
  always_comb begin
    rounded = (33'(size_q) + cmask) & ~cmask;
    if (chunk_size_i == 32'd0) begin
      rounded = 33'd0;
    end
    new_cap = 33'(chunk_size_i);
    if (size_q > chunk_size_i) begin
      new_cap = (rounded < 33'(size_q)) ? 33'(size_q) : rounded;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cleared_d   = cleared_q;
    size_d      = size_q;
    align_d     = align_q;
    at_d        = at_q;
    cap_d       = cap_q;
    rsp_d       = rsp_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '{capacity: cap_q, fill: end_sum[32:0]};

    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          size_d  = req_i.size_bytes;
          align_d = req_i.alignment;
          idx_d   = '0;
          rsp_d   = '0;
          rsp_d.status = StatusOk;
          if (req_i.op == OpClear) begin
            cleared_d = '1;
            state_d   = SDone;
          end else if (req_i.size_bytes == 32'd0 || req_i.alignment == 17'd0) begin
            rsp_d.status = StatusSkip;
            state_d      = SDone;
          end else if (count_q == '0) begin
            state_d = SOpen;
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        state_d = SAlign;
      end
      SAlign: begin
        at_d    = ({1'b0, fill_rd} + amask) & ~amask;
        cap_d   = ram_rdata_i.capacity;
        state_d = SCheck;
      end
      SCheck: begin
        if (fits) begin
          ram_we_o             = 1'b1;
          cleared_d[idx_q]     = 1'b0;
          rsp_d.status         = StatusOk;
          rsp_d.pool_index     = 3'(idx_q);
          rsp_d.offset         = at_q[31:0];
          state_d              = SDone;
        end else if (last_pool) begin
          state_d = SOpen;
        end else begin
          idx_d   = idx_q + PoolIdxW'(1);
          state_d = SRead;
        end
      end
      SOpen: begin
        if (count_q == CountW'(MaxPools)) begin
          rsp_d.status = StatusFull;
        end else begin
          ram_we_o                           = 1'b1;
          ram_waddr_o                        = count_q[PoolIdxW-1:0];
          ram_wdata_o                        = '{capacity: new_cap, fill: 33'(size_q)};
          cleared_d[count_q[PoolIdxW-1:0]]   = 1'b0;
          count_d                            = count_q + CountW'(1);
          rsp_d.status                       = StatusOk;
          rsp_d.pool_index                   = 3'(count_q[PoolIdxW-1:0]);
          rsp_d.offset                       = 32'd0;
          rsp_d.new_pool                     = 1'b1;
          rsp_d.new_pool_size                = new_cap;
        end
        state_d = SDone;
      end
      SDone: begin
        if (rsp_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      cleared_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cleared_q <= cleared_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    size_q  <= size_d;
    align_q <= align_d;
    at_q    <= at_d;
    cap_q   <= cap_d;
    rsp_q   <= rsp_d;
  end

  assign ram_raddr_o = idx_q;
  assign req_ready_o = (state_q == SIdle);
  assign rsp_valid_o = (state_q == SDone);
  assign rsp_o       = rsp_q;

  // table never holds more pools than it has entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxPools))
    else $error("pool count beyond table size");

  // entries are written only on a fit or when a pool is opened
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == SCheck || state_q == SOpen))
    else $error("table write outside check or open");

  // scan never looks at a pool that is not open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAlign || state_q == SCheck) |-> (CountW'(idx_q) < count_q))
    else $error("scan past open pools");

  // opening a pool bumps the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOpen && ram_we_o) |=> (count_q == $past(count_q) + CountW'(1)))
    else $error("pool count not advanced on open");

  // a clear marks every entry as zero fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && req_valid_i && req_i.op == OpClear) |=> (cleared_q == '1))
    else $error("clear did not mark all pools");

endmodule

// ----- src/multi_pool_bump_allocator_top.sv -----
// multi-pool bump allocator
//
// input channel (in_valid_i / in_ready_o / in_data_i) carries one request item:
// op selects allocate or clear-all-fills, with size and power-of-two alignment.
// output channel (out_valid_o / out_ready_i / out_data_o) returns one result
// item per request: status, pool index, aligned offset, and the size of a pool
// when the request had to open one.
// chunk size is written through cfg_valid_i / cfg_chunk_size_i; the port is
// always ready and should only be written while no request is in flight.
//
// operation: a clear or a rejected request goes straight to the result; an
// allocation runs table read, align and fit check for each pool scanned, then
// opens a new pool or finds the table full when no open pool fits. the scan
// is first-fit over the open pools through the single read port of the pool
// table memory, so the rate is set by the number of pools visited. the result
// reaches out_valid_o through the output register after the controller finishes.
// the output register frees the controller when a result is taken; a stall
// on out_ready_i holds the result and blocks the next request from finishing.
// reset empties the pool table (count zero) and sets chunk size to 32 MiB.
module multi_pool_bump_allocator_top
  import mpba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_chunk_size_i
);

  logic [31:0]         chunk_q;
  logic                out_valid_q;
  rsp_t                out_data_q;

  logic                rsp_valid;
  logic                rsp_ready;
  rsp_t                rsp;

  // pool table memory ports
  logic                ram_we;
  logic [PoolIdxW-1:0] ram_waddr;
  pool_t               ram_wdata;
  logic [PoolIdxW-1:0] ram_raddr;
  logic [$bits(pool_t)-1:0] ram_rdata;

  // chunk size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= ChunkReset;
    end else if (cfg_valid_i) begin
      chunk_q <= cfg_chunk_size_i;
    end
  end

  mpba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (in_data_i),
    .chunk_size_i (chunk_q),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_o        (rsp),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (pool_t'(ram_rdata))
  );

  // capacity and fill of each pool live side by side in one entry
  mpba_ram #(
    .Width ($bits(pool_t)),
    .Depth (MaxPools)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register, refilled in the cycle the held item leaves
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- verif/tb_multi_pool_bump_allocator_top.sv -----
`timescale 1ns / 100ps

module tb_multi_pool_bump_allocator_top;
  import mpba_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 9;
  // allows for the deepest scan of 8 pools plus setup and output register
  localparam int unsigned DrainWait  = 40;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  req_t        in_data   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;

  logic        in_ready;
  logic        out_valid;
  rsp_t        out_data;
  logic        cfg_ready;

  multi_pool_bump_allocator_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .in_data_i       (in_data),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_o      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_chunk_size_i(cfg_data)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // requests waiting to be sent, and results owed by the block in order
  req_t request_q[$];
  rsp_t expected_rsp_q[$];

  // shadow copy of the pool table and the chunk register
  logic [32:0] pool_cap [MaxPools];
  logic [32:0] pool_fil [MaxPools];
  int unsigned pool_cnt;
  logic [31:0] chunk_cur;

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt   = 0;
  int unsigned n_req     = 0;
  int unsigned n_placed  = 0;
  int unsigned n_opened  = 0;
  int unsigned n_skip    = 0;
  int unsigned n_full    = 0;
  int unsigned n_clear   = 0;

  // first-fit placement of one request against the shadow pool table
  function automatic rsp_t place_request(req_t r);
    rsp_t        res;
    logic [63:0] size64;
    logic [63:0] m;
    logic [63:0] at;
    logic [63:0] cap;
    logic [63:0] cm;
    res = '0;
    if (r.op == OpClear) begin
      // fills go back to zero, the pools stay open
      for (int k = 0; k < MaxPools; k++) pool_fil[k] = '0;
      return res;
    end
    if (r.size_bytes == '0 || r.alignment == '0) begin
      res.status = StatusSkip;
      return res;
    end
    size64 = {32'd0, r.size_bytes};
    // mask form of align-up, also used for alignments that are not a power of two
    m = {47'd0, r.alignment} - 64'd1;
    for (int k = 0; k < pool_cnt; k++) begin
      at = ({31'd0, pool_fil[k]} + m) & ~m;
      if (at + size64 <= {31'd0, pool_cap[k]}) begin
        pool_fil[k]    = at[32:0] + size64[32:0];
        res.pool_index = 3'(k);
        res.offset     = at[31:0];
        return res;
      end
    end
    if (pool_cnt >= MaxPools) begin
      res.status = StatusFull;
      return res;
    end
    // open a pool: chunk size, or the request rounded up to chunk multiples
    cap = {32'd0, chunk_cur};
    if (size64 > cap) begin
      cm  = cap - 64'd1;
      cap = (size64 + cm) & ~cm;
      // odd or zero chunk can round below the request
      if (cap < size64) cap = size64;
    end
    pool_cap[pool_cnt]  = cap[32:0];
    pool_fil[pool_cnt]  = size64[32:0];
    res.pool_index      = 3'(pool_cnt);
    res.new_pool        = 1'b1;
    res.new_pool_size   = cap[32:0];
    pool_cnt++;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_cnt++;
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
  endtask

  task automatic add_request(input op_e op, input logic [31:0] size, input logic [16:0] align);
    req_t item;
    item.op         = op;
    item.size_bytes = size;
    item.alignment  = align;
    request_q = {request_q, item};
  endtask

  // sender holds off here until every result owed has come back
  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // request driver: one item per handshake, random gap after each accepted item
  int unsigned send_gap;
  bit          send_calm = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // item still waiting, keep valid and payload as they are
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (request_q.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= request_q.pop_front();
      // now and then switch between back-to-back and gapped sending
      if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
      send_gap <= send_calm ? 0 : $urandom_range(0, 6);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor: predicts on accepted requests and config writes, checks results
  int unsigned hold_cnt;
  bit          recv_calm = 1'b0;

  always @(posedge clk or negedge rst_n) begin : mon_blk
    rsp_t        want;
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b1;
      hold_cnt  <= 0;
      pool_cnt  = 0;
      chunk_cur = ChunkReset;
      for (int k = 0; k < MaxPools; k++) begin
        pool_cap[k] = '0;
        pool_fil[k] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) chunk_cur = cfg_data;

      if (in_valid && in_ready) begin
        want = place_request(in_data);
        expected_rsp_q = {expected_rsp_q, want};
        n_req++;
        if (in_data.op == OpClear) n_clear++;
        else if (want.status == StatusSkip) n_skip++;
        else if (want.status == StatusFull) n_full++;
        else n_placed++;
        if (want.new_pool) n_opened++;
      end

      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          flag_mismatch("result with nothing pending, offset", 64'(out_data.offset), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_data.status !== want.status)
            flag_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.pool_index !== want.pool_index)
            flag_mismatch("pool_index", 64'(out_data.pool_index), 64'(want.pool_index));
          if (out_data.offset !== want.offset)
            flag_mismatch("offset", 64'(out_data.offset), 64'(want.offset));
          if (out_data.new_pool !== want.new_pool)
            flag_mismatch("new_pool", 64'(out_data.new_pool), 64'(want.new_pool));
          if (out_data.new_pool_size !== want.new_pool_size)
            flag_mismatch("new_pool_size", 64'(out_data.new_pool_size),
                          64'(want.new_pool_size));
        end
        // stall drawn per result, with calm stretches of none
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        stall = recv_calm ? 0 : $urandom_range(0, 6);
        hold_cnt  <= stall;
        out_ready <= (stall == 0);
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= (hold_cnt == 1);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               expected_rsp_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  logic [31:0] chunk_plan [NumPhases];
  int unsigned phase_len  [NumPhases];
  int unsigned phase_wmax [NumPhases];
  int unsigned phase_big  [NumPhases];

  initial begin
    req_t        item;
    int unsigned pick;
    int unsigned w;

    // chunk settings per phase: zero, odd, both ends, random, reset value, random power of two, all ones
    chunk_plan = '{32'd0, 32'h0000_3000, 32'd4096, 32'h8000_0000, 32'd0,
                   ChunkReset, 32'd0, 32'd4096, 32'hFFFF_FFFF};
    chunk_plan[4] = $urandom;
    chunk_plan[6] = 32'd1 << $urandom_range(12, 31);
    // early phases open few pools so that pools get opened under several chunks
    phase_len  = '{60, 60, 120, 150, 150, 400, 400, 300, 250};
    phase_wmax = '{10, 12, 12, 20, 16, 24, 20, 12, 32};
    phase_big  = '{4, 4, 3, 3, 10, 10, 10, 10, 10};

    // directed part, under the reset chunk of 32 MiB
    add_request(OpAlloc, 32'd1, 17'd1);                // opens pool 0
    add_request(OpAlloc, 32'd100, 17'h10000);          // largest alignment
    add_request(OpAlloc, 32'd0, 17'd4);                // zero size
    add_request(OpAlloc, 32'd8, 17'd0);                // zero alignment
    add_request(OpAlloc, 32'd0, 17'd0);                // both zero
    add_request(OpAlloc, 32'd5, 17'd3);                // alignment not a power of two
    add_request(OpAlloc, 32'd7, 17'h1FFFF);            // all alignment bits set
    add_request(OpAlloc, 32'h0200_0000, 17'd1);        // exactly one chunk, new pool
    add_request(OpAlloc, 32'h0200_0001, 17'd16);       // rounds up to two chunks
    add_request(OpClear, 32'hFFFF_FFFF, 17'h1FFFF);    // clear with junk fields
    add_request(OpAlloc, 32'h0200_0000, 17'h10000);    // fills pool 0 to the brim
    add_request(OpAlloc, 32'hFFFF_FFFF, 17'd1);        // largest size, 33-bit pool
    add_request(OpAlloc, 32'd1, 17'd1);                // first fit skips a full pool
    add_request(OpClear, 32'd0, 17'd0);
    add_request(OpAlloc, 32'hFFFF_FFFF, 17'h10000);    // lands in the big pool

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      // chunk only changes with nothing in flight
      wait_drained();
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= chunk_plan[p];
      @(negedge clk);
      while (!cfg_ready) @(negedge clk);
      @(posedge clk);
      cfg_valid <= 1'b0;

      for (int j = 0; j < phase_len[p]; j++) begin
        pick = $urandom_range(0, 99);
        item = '0;
        if (pick < 8) begin
          // clear, other fields are don't-care noise
          item.op         = OpClear;
          item.size_bytes = $urandom;
          item.alignment  = 17'($urandom);
        end else begin
          item.op = OpAlloc;
          // size drawn over a spread of magnitudes, rarely up to full width
          w = ($urandom_range(0, 99) < phase_big[p]) ? $urandom_range(1, 32)
                                                      : $urandom_range(1, phase_wmax[p]);
          item.size_bytes = $urandom & (32'hFFFF_FFFF >> (32 - w));
          if ($urandom_range(0, 9) < 8) item.alignment = 17'd1 << $urandom_range(0, 16);
          else item.alignment = 17'($urandom);
          if (pick < 13) begin
            // rejected requests
            case ($urandom_range(0, 2))
              0: item.size_bytes = '0;
              1: item.alignment  = '0;
              default: begin
                item.size_bytes = '0;
                item.alignment  = '0;
              end
            endcase
          end
        end
        request_q = {request_q, item};
      end
    end

    wait_drained();
    // catch any stray result after the last one owed
    repeat (DrainWait) @(posedge clk);

    $display("ran %0d requests over %0d chunk settings: %0d placed, %0d pools opened",
             n_req, NumPhases + 1, n_placed, n_opened);
    $display("rejected %0d, table full %0d, clears %0d, mismatches %0d",
             n_skip, n_full, n_clear, err_cnt);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
